// ----- sv/lzsf_pkg.sv -----
// Shared types and constants of the largest zero square finder.
package lzsf_pkg;

  // Field widths fixed by the data format
  localparam int SIDE_W   = 7;
  localparam int COUNT_W  = 13;
  localparam int COLCNT_W = 7;
  localparam int ROW_W    = 16;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 1;

  // Saturation limits of the result fields
  localparam logic [SIDE_W-1:0]  SIDE_MAX  = 7'd127;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 13'd8191;

  // Register reset values
  localparam logic [COLCNT_W-1:0] COLUMN_COUNT_RST = 7'd64;
  localparam logic [ROW_W-1:0]    ROW_COUNT_RST    = 16'd64;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COLUMN_COUNT = 1'b0,
    CFG_ROW_COUNT    = 1'b1
  } lzsf_cfg_idx_e;

  // Effective configuration: zero counts already read as one
  typedef struct packed {
    logic [COLCNT_W-1:0] column_count;
    logic [ROW_W-1:0]    row_count;
  } lzsf_cfg_t;

endpackage

// ----- sv/lzsf_if.sv -----
// Request channel interfaces: matrix cells in, square results out.
interface lzsf_cell_if;
  logic valid;
  logic ready;
  logic cell_bit;

  modport source (output valid, output cell_bit, input ready);
  modport sink (input valid, input cell_bit, output ready);
endinterface

interface lzsf_result_if import lzsf_pkg::*;;
  logic               valid;
  logic               ready;
  logic [SIDE_W-1:0]  best_side;
  logic [COUNT_W-1:0] best_zero_count;

  modport source (output valid, output best_side, output best_zero_count, input ready);
  modport sink (input valid, input best_side, input best_zero_count, output ready);
endinterface

// ----- sv/lzsf_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module lzsf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port; read returns the old contents on a same-address write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ----- sv/lzsf_cfg_regs.sv -----
// Configuration registers with write decode and zero-count handling.
module lzsf_cfg_regs import lzsf_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  output lzsf_cfg_t            cfg_o
);

  logic [COLCNT_W-1:0] column_count_q;
  logic [ROW_W-1:0]    row_count_q;

  // Decode and hold register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_count_q <= COLUMN_COUNT_RST;
      row_count_q    <= ROW_COUNT_RST;
    end else if (cfg_we_i) begin
      unique case (lzsf_cfg_idx_e'(cfg_index_i))
        CFG_COLUMN_COUNT: column_count_q <= cfg_data_i[COLCNT_W-1:0];
        CFG_ROW_COUNT:    row_count_q    <= cfg_data_i[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  // Read a zero count as one
  assign cfg_o.column_count = (column_count_q == '0) ? COLCNT_W'(1) : column_count_q;
  assign cfg_o.row_count    = (row_count_q == '0) ? ROW_W'(1) : row_count_q;

endmodule

// ----- sv/lzsf_side_calc.sv -----
// Square side at one cell: zero if blocked, else one more than the smallest neighbour.
module lzsf_side_calc import lzsf_pkg::*; (
  input  logic              cell_bit_i,
  input  logic [SIDE_W-1:0] up_i,
  input  logic [SIDE_W-1:0] left_i,
  input  logic [SIDE_W-1:0] upper_left_i,
  output logic [SIDE_W-1:0] side_o
);

  logic [SIDE_W-1:0] min_ab;
  logic [SIDE_W-1:0] min_abc;
  logic [SIDE_W:0]   sum;

  // Three-way minimum, increment, saturate
  always_comb begin
    min_ab  = (up_i < left_i) ? up_i : left_i;
    min_abc = (min_ab < upper_left_i) ? min_ab : upper_left_i;
    sum     = {1'b0, min_abc} + (SIDE_W + 1)'(1);
    if (cell_bit_i) begin
      side_o = '0;
    end else if (sum > {1'b0, SIDE_MAX}) begin
      side_o = SIDE_MAX;
    end else begin
      side_o = sum[SIDE_W-1:0];
    end
  end

endmodule

// ----- sv/largest_zero_square_finder_top.sv -----
// Largest all-zero square finder over a streamed binary matrix.
//
// Cells arrive one per request in row-major order; column and row counts come
// from the configuration port (a zero count acts as one, a column count above
// MAX_COLUMNS acts as MAX_COLUMNS). The block takes one cell every cycle: a
// cell is registered together with a read of the previous row's square side
// from a MAX_COLUMNS-deep RAM, and the next cycle works out the new side,
// writes it back and may already take the following cell. The single RAM read
// and write port per cycle sets this rate. One result request (best side and
// its square) leaves from an output register, loaded when the last cell of a
// matrix retires from the cell register; input keeps flowing while that result
// waits, and stalls only when a second matrix ends before the first result is
// taken. The RAM needs no clearing pass: a fill count marks which columns hold
// data of the current matrix, and all others read as zero.
module largest_zero_square_finder_top import lzsf_pkg::*; #(
  parameter int MAX_COLUMNS = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  lzsf_cell_if.sink            cell_i,
  lzsf_result_if.source        result_o
);

  localparam int CW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int NW = $clog2(MAX_COLUMNS + 1);
  localparam int KW = (NW > COLCNT_W) ? NW : COLCNT_W;
  localparam logic [KW-1:0] MAX_K = KW'(MAX_COLUMNS);

  lzsf_cfg_t cfg;

  logic [KW-1:0]    cols_eff;
  logic             accept;
  logic             retire;
  logic             last_col;
  logic             last_row;

  logic [CW-1:0]    col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;

  logic             s1_valid_q, s1_valid_d;
  logic             s1_cell_q;
  logic [CW-1:0]    s1_col_q;
  logic             s1_end_q;
  logic             byp_q;
  logic [SIDE_W-1:0] byp_side_q;

  logic [NW-1:0]    fill_q;
  logic [SIDE_W-1:0] left_q;
  logic [SIDE_W-1:0] upper_left_q;
  logic [SIDE_W-1:0] best_q;

  logic [SIDE_W-1:0] rdata;
  logic [SIDE_W-1:0] up_raw;
  logic [SIDE_W-1:0] up;
  logic [SIDE_W-1:0] left_in;
  logic [SIDE_W-1:0] upper_left_in;
  logic [SIDE_W-1:0] side;
  logic [SIDE_W-1:0] best_new;
  logic [2*SIDE_W-1:0] square;
  logic [COUNT_W-1:0]  count_sat;
  logic [NW-1:0]    col_next_fill;

  logic               out_valid_q, out_valid_d;
  logic [SIDE_W-1:0]  out_side_q;
  logic [COUNT_W-1:0] out_count_q;

  lzsf_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Clamp the column count to the row buffer depth
  assign cols_eff = (KW'(cfg.column_count) > MAX_K) ? MAX_K : KW'(cfg.column_count);

  // Handshake: retire the registered cell unless its result has nowhere to go
  assign retire       = s1_valid_q & ~(s1_end_q & out_valid_q & ~result_o.ready);
  assign cell_i.ready = ~s1_valid_q | retire;
  assign accept       = cell_i.valid & cell_i.ready;

  // Position of the incoming cell
  assign last_col = (KW'(col_q) + KW'(1)) >= cols_eff;
  assign last_row = ({1'b0, row_q} + (ROW_W + 1)'(1)) >= {1'b0, cfg.row_count};

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + ROW_W'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  assign s1_valid_d = accept | (s1_valid_q & ~retire);

  lzsf_ram #(
    .WIDTH (SIDE_W),
    .DEPTH (MAX_COLUMNS)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (retire),
    .waddr_i (s1_col_q),
    .wdata_i (side),
    .re_i    (accept),
    .raddr_i (col_q),
    .rdata_o (rdata)
  );

  // Neighbours of the registered cell; unfilled columns read as zero
  assign up_raw        = byp_q ? byp_side_q : rdata;
  assign up            = (NW'(s1_col_q) < fill_q) ? up_raw : '0;
  assign left_in       = (s1_col_q == '0) ? '0 : left_q;
  assign upper_left_in = (s1_col_q == '0) ? '0 : upper_left_q;

  lzsf_side_calc u_side (
    .cell_bit_i   (s1_cell_q),
    .up_i         (up),
    .left_i       (left_in),
    .upper_left_i (upper_left_in),
    .side_o       (side)
  );

  // Best side and its saturated square
  assign best_new      = (side > best_q) ? side : best_q;
  assign square        = (2*SIDE_W)'(best_new) * (2*SIDE_W)'(best_new);
  assign count_sat     = (square > (2*SIDE_W)'(COUNT_MAX)) ? COUNT_MAX : square[COUNT_W-1:0];
  assign col_next_fill = NW'(s1_col_q) + NW'(1);

  assign out_valid_d = (retire & s1_end_q) | (out_valid_q & ~result_o.ready);

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q        <= '0;
      row_q        <= '0;
      s1_valid_q   <= 1'b0;
      byp_q        <= 1'b0;
      fill_q       <= '0;
      left_q       <= '0;
      upper_left_q <= '0;
      best_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      col_q       <= col_d;
      row_q       <= row_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (accept) begin
        // Forward a side written in the same cycle as its column is read
        byp_q <= retire & (s1_col_q == col_q);
      end
      if (retire) begin
        left_q       <= side;
        upper_left_q <= up;
        if (s1_end_q) begin
          best_q <= '0;
          fill_q <= '0;
        end else begin
          best_q <= best_new;
          if (col_next_fill > fill_q) begin
            fill_q <= col_next_fill;
          end
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_cell_q  <= cell_i.cell_bit;
      s1_col_q   <= col_q;
      s1_end_q   <= last_col & last_row;
      byp_side_q <= side;
    end
    if (retire & s1_end_q) begin
      out_side_q  <= best_new;
      out_count_q <= count_sat;
    end
  end

  assign result_o.valid           = out_valid_q;
  assign result_o.best_side       = out_side_q;
  assign result_o.best_zero_count = out_count_q;

endmodule
